// ===== src/breakpoint_and_step_unit_macros.svh =====
// Assertion macros for the breakpoint and step unit checker.
`ifndef BREAKPOINT_AND_STEP_UNIT_MACROS_SVH
`define BREAKPOINT_AND_STEP_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BSU_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("breakpoint_and_step_unit: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BSU_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("breakpoint_and_step_unit: check failed");

`endif

// ===== src/bsu_pkg.sv =====
// Shared types, codes and constants of the breakpoint and step unit.
`timescale 1ns / 1ps

package bsu_pkg;

  localparam int unsigned ANCHOR_SLOTS_DEF = 32;
  localparam int unsigned BP_SLOTS_DEF     = 16;
  localparam int unsigned AIDX_W           = 8;
  localparam int unsigned BIDX_W           = 6;
  localparam logic [31:0] HITS_MAX         = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    KIND_STMT   = 3'd0,
    KIND_THROW  = 3'd1,
    KIND_ADD    = 3'd2,
    KIND_DEL    = 3'd3,
    KIND_RESUME = 3'd4,
    KIND_QUERY  = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    MODE_CONTINUE = 3'd0,
    MODE_INTO     = 3'd1,
    MODE_OVER     = 3'd2,
    MODE_OUT      = 3'd3,
    MODE_INITIAL  = 3'd4
  } run_mode_e;

  typedef enum logic [1:0] {
    REASON_BP      = 2'd0,
    REASON_INITIAL = 2'd1,
    REASON_STEP    = 2'd2,
    REASON_THROW   = 2'd3
  } reason_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_EXHAUSTED = 2'd1,
    STATUS_NO_BP     = 2'd2,
    STATUS_NOT_STOP  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_A_LAUNCH,
    ST_A_WAIT,
    ST_B_LAUNCH,
    ST_B_WAIT,
    ST_COMMIT
  } bsu_state_e;

  typedef struct packed {
    logic [15:0] func;
    logic [15:0] pc;
  } a_key_t;

  typedef struct packed {
    logic              tok;
    logic              hit;
    logic [15:0]       best_num;
    logic [BIDX_W-1:0] best_slot;
    logic              free_hit;
    logic [AIDX_W-1:0] free_idx;
  } a_carry_t;

  typedef struct packed {
    logic              set;
    logic [AIDX_W-1:0] idx;
    logic [15:0]       func;
    logic [15:0]       pc;
    logic [BIDX_W-1:0] owner;
    logic [15:0]       num;
    logic              clr;
    logic [BIDX_W-1:0] clr_owner;
  } a_wr_t;

  typedef struct packed {
    logic              by_slot;
    logic              slot_ok;
    logic [BIDX_W-1:0] slot;
    logic [15:0]       number;
    logic              inc;
  } b_key_t;

  typedef struct packed {
    logic              tok;
    logic              found;
    logic [BIDX_W-1:0] slot;
    logic [31:0]       hits;
    logic              free_hit;
    logic [BIDX_W-1:0] free_slot;
  } b_carry_t;

  typedef struct packed {
    logic              set;
    logic              clr;
    logic [BIDX_W-1:0] slot;
    logic [15:0]       number;
  } b_wr_t;

endpackage

// ===== src/bsu_anchor_cell.sv =====
// One anchor slot: holds a location and passes the match search to the next cell.
`timescale 1ns / 1ps

module bsu_anchor_cell import bsu_pkg::*; #(
  parameter int unsigned Idx = 0
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  a_key_t   key_i,
  input  a_wr_t    wr_i,
  input  a_carry_t carry_i,
  output a_carry_t carry_o
);

  logic              valid_q;
  logic [15:0]       func_q;
  logic [15:0]       pc_q;
  logic [BIDX_W-1:0] owner_q;
  logic [15:0]       num_q;
  logic              wr_here;
  logic              match;
  a_carry_t          carry_d, carry_q;

  assign wr_here = wr_i.set && (wr_i.idx == AIDX_W'(Idx));
  assign match   = valid_q && (func_q == key_i.func) && (pc_q == key_i.pc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (wr_here) begin
      valid_q <= 1'b1;
    end else if (wr_i.clr && valid_q && (owner_q == wr_i.clr_owner)) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_here) begin
      func_q  <= wr_i.func;
      pc_q    <= wr_i.pc;
      owner_q <= wr_i.owner;
      num_q   <= wr_i.num;
    end
  end

  always_comb begin
    carry_d = carry_i;
    if (carry_i.tok) begin
      if (match && (!carry_i.hit || (num_q < carry_i.best_num))) begin
        carry_d.hit       = 1'b1;
        carry_d.best_num  = num_q;
        carry_d.best_slot = owner_q;
      end
      if (!carry_i.free_hit && !valid_q) begin
        carry_d.free_hit = 1'b1;
        carry_d.free_idx = AIDX_W'(Idx);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_q <= '0;
    end else begin
      carry_q <= carry_d;
    end
  end

  assign carry_o = carry_q;

endmodule

// ===== src/bsu_bp_cell.sv =====
// One breakpoint slot: number and hit count, with the lookup passed down the row.
`timescale 1ns / 1ps

module bsu_bp_cell import bsu_pkg::*; #(
  parameter int unsigned Idx = 0
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  b_key_t   key_i,
  input  b_wr_t    wr_i,
  input  b_carry_t carry_i,
  output b_carry_t carry_o
);

  logic        valid_q;
  logic [15:0] number_q;
  logic [31:0] hits_q;
  logic [31:0] hits_next;
  logic        here;
  logic        match;
  b_carry_t    carry_d, carry_q;

  assign here      = (wr_i.slot == BIDX_W'(Idx));
  assign match     = valid_q && (key_i.by_slot ?
                     (key_i.slot_ok && (key_i.slot == BIDX_W'(Idx))) :
                     (number_q == key_i.number));
  assign hits_next = (key_i.inc && (hits_q != HITS_MAX)) ? hits_q + 32'd1 : hits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (wr_i.set && here) begin
      valid_q <= 1'b1;
    end else if (wr_i.clr && here) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.set && here) begin
      number_q <= wr_i.number;
      hits_q   <= '0;
    end else if (carry_i.tok && match) begin
      hits_q   <= hits_next;
    end
  end

  always_comb begin
    carry_d = carry_i;
    if (carry_i.tok) begin
      if (match && !carry_i.found) begin
        carry_d.found = 1'b1;
        carry_d.slot  = BIDX_W'(Idx);
        carry_d.hits  = hits_next;
      end
      if (!carry_i.free_hit && !valid_q) begin
        carry_d.free_hit  = 1'b1;
        carry_d.free_slot = BIDX_W'(Idx);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_q <= '0;
    end else begin
      carry_q <= carry_d;
    end
  end

  assign carry_o = carry_q;

endmodule

// ===== src/breakpoint_and_step_unit.sv =====
// Top level of the breakpoint and step unit: item control, cell rows and result word.
// One word at a time: a result strobes on done_o after the anchor search, the breakpoint search and the commit state.
// The search token walks the anchor row one cell a cycle, then the breakpoint row.
// A new word is taken in the strobe cycle at the earliest; none is taken while the unit is busy.
// Reset clears all valid bits, the mode to initial stop, numbering to one; no clearing pass.
// The throw register is written at any cycle its channel handshakes; results cannot stall.
`timescale 1ns / 1ps

module breakpoint_and_step_unit import bsu_pkg::*; #(
  parameter int unsigned ANCHOR_SLOTS     = ANCHOR_SLOTS_DEF,
  parameter int unsigned BREAKPOINT_SLOTS = BP_SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,
  input  logic [2:0]  kind_i,
  input  logic [15:0] func_idx_i,
  input  logic [15:0] pc_i,
  input  logic [15:0] line_i,
  input  logic [15:0] depth_i,
  input  logic [1:0]  mode_i,
  input  logic        new_bp_i,
  input  logic [15:0] bp_id_i,
  output logic        done_o,
  output logic        stopped_o,
  output logic [1:0]  reason_o,
  output logic [15:0] hit_number_o,
  output logic [15:0] stop_func_o,
  output logic [15:0] stop_pc_o,
  output logic [15:0] stop_line_o,
  output logic [15:0] stop_depth_o,
  output logic [1:0]  status_o,
  output logic [31:0] hits_o
);

  bsu_state_e state_q, state_d;

  kind_e       kind_q;
  logic [15:0] func_q, pc_q, line_q, depth_q, bp_id_q;
  logic [1:0]  mode_q;
  logic        new_bp_q;

  logic              bot_q;
  run_mode_e         run_mode_q, run_mode_d;
  logic [15:0]       step_depth_q, step_depth_d;
  logic [15:0]       next_num_q, next_num_d;
  logic              last_valid_q, last_valid_d;
  logic [BIDX_W-1:0] last_slot_q, last_slot_d;
  logic [15:0]       last_num_q, last_num_d;
  logic              frozen_q, frozen_d;

  a_carry_t a_res_q;
  b_carry_t b_res_q;
  a_carry_t a_chain [ANCHOR_SLOTS+1];
  b_carry_t b_chain [BREAKPOINT_SLOTS+1];
  a_key_t   a_key;
  b_key_t   b_key;
  a_wr_t    a_wr;
  b_wr_t    b_wr;

  logic a_launch, b_launch, commit, accept;

  logic        stop;
  reason_e     reason;
  status_e     status;
  logic [15:0] num;
  logic [31:0] hits;

  logic        done_q, stopped_q;
  logic [1:0]  reason_q, status_q;
  logic [15:0] hit_number_q, stop_func_q, stop_pc_q, stop_line_q, stop_depth_q;
  logic [31:0] hits_q;

  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (start) state_d = ST_A_LAUNCH;
      ST_A_LAUNCH: state_d = ST_A_WAIT;
      ST_A_WAIT:   if (a_chain[ANCHOR_SLOTS].tok) state_d = ST_B_LAUNCH;
      ST_B_LAUNCH: state_d = ST_B_WAIT;
      ST_B_WAIT:   if (b_chain[BREAKPOINT_SLOTS].tok) state_d = ST_COMMIT;
      ST_COMMIT:   state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    busy     = 1'b1;
    a_launch = 1'b0;
    b_launch = 1'b0;
    commit   = 1'b0;
    unique case (state_q)
      ST_IDLE:     busy     = 1'b0;
      ST_A_LAUNCH: a_launch = 1'b1;
      ST_B_LAUNCH: b_launch = 1'b1;
      ST_COMMIT:   commit   = 1'b1;
      default:     busy     = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q   <= kind_e'(kind_i);
      func_q   <= func_idx_i;
      pc_q     <= pc_i;
      line_q   <= line_i;
      depth_q  <= depth_i;
      mode_q   <= mode_i;
      new_bp_q <= new_bp_i;
      bp_id_q  <= bp_id_i;
    end
    if ((state_q == ST_A_WAIT) && a_chain[ANCHOR_SLOTS].tok) begin
      a_res_q <= a_chain[ANCHOR_SLOTS];
    end
    if ((state_q == ST_B_WAIT) && b_chain[BREAKPOINT_SLOTS].tok) begin
      b_res_q <= b_chain[BREAKPOINT_SLOTS];
    end
  end

  always_comb begin
    a_chain[0]     = '0;
    a_chain[0].tok = a_launch;
    b_chain[0]     = '0;
    b_chain[0].tok = b_launch;
    a_key.func     = func_q;
    a_key.pc       = pc_q;
    b_key.by_slot  = (kind_q == KIND_STMT);
    b_key.slot_ok  = a_res_q.hit;
    b_key.slot     = a_res_q.best_slot;
    b_key.number   = bp_id_q;
    b_key.inc      = (kind_q == KIND_STMT) && a_res_q.hit;
  end

  for (genvar i = 0; i < ANCHOR_SLOTS; i++) begin : g_anchor
    bsu_anchor_cell #(.Idx(i)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .key_i   (a_key),
      .wr_i    (a_wr),
      .carry_i (a_chain[i]),
      .carry_o (a_chain[i+1])
    );
  end

  for (genvar j = 0; j < BREAKPOINT_SLOTS; j++) begin : g_bp
    bsu_bp_cell #(.Idx(j)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .key_i   (b_key),
      .wr_i    (b_wr),
      .carry_i (b_chain[j]),
      .carry_o (b_chain[j+1])
    );
  end

  always_comb begin
    stop         = 1'b0;
    reason       = REASON_BP;
    status       = STATUS_OK;
    num          = '0;
    hits         = '0;
    a_wr         = '0;
    a_wr.idx     = a_res_q.free_idx;
    a_wr.func    = func_q;
    a_wr.pc      = pc_q;
    a_wr.owner   = last_slot_q;
    a_wr.num     = last_num_q;
    a_wr.clr_owner = b_res_q.slot;
    b_wr         = '0;
    b_wr.slot    = b_res_q.free_slot;
    b_wr.number  = next_num_q;
    run_mode_d   = run_mode_q;
    step_depth_d = step_depth_q;
    next_num_d   = next_num_q;
    last_valid_d = last_valid_q;
    last_slot_d  = last_slot_q;
    last_num_d   = last_num_q;
    frozen_d     = frozen_q;
    case (kind_q)
      KIND_STMT: begin
        if (a_res_q.hit) begin
          stop = 1'b1;
          num  = a_res_q.best_num;
          hits = b_res_q.hits;
        end else begin
          case (run_mode_q) inside
            MODE_INITIAL, MODE_INTO: stop = 1'b1;
            MODE_OVER:               stop = (depth_q <= step_depth_q);
            MODE_OUT:                stop = (depth_q < step_depth_q);
            default:                 stop = 1'b0;
          endcase
          reason = (run_mode_q == MODE_INITIAL) ? REASON_INITIAL : REASON_STEP;
        end
      end
      KIND_THROW: begin
        stop   = bot_q;
        reason = REASON_THROW;
      end
      KIND_ADD: begin
        if (new_bp_q) begin
          if (!b_res_q.free_hit || !a_res_q.free_hit || (next_num_q == 16'd0)) begin
            status = STATUS_EXHAUSTED;
          end else begin
            b_wr.set     = commit;
            a_wr.set     = commit;
            a_wr.owner   = b_res_q.free_slot;
            a_wr.num     = next_num_q;
            num          = next_num_q;
            next_num_d   = next_num_q + 16'd1;
            last_valid_d = 1'b1;
            last_slot_d  = b_res_q.free_slot;
            last_num_d   = next_num_q;
          end
        end else if (!last_valid_q) begin
          status = STATUS_NO_BP;
        end else if (!a_res_q.free_hit) begin
          status = STATUS_EXHAUSTED;
        end else begin
          a_wr.set = commit;
          num      = last_num_q;
        end
      end
      KIND_DEL: begin
        if (!b_res_q.found) begin
          status = STATUS_NO_BP;
        end else begin
          b_wr.clr  = commit;
          b_wr.slot = b_res_q.slot;
          a_wr.clr  = commit;
          if (last_valid_q && (last_slot_q == b_res_q.slot)) last_valid_d = 1'b0;
          num = bp_id_q;
        end
      end
      KIND_RESUME: begin
        if (!frozen_q) begin
          status = STATUS_NOT_STOP;
        end else begin
          run_mode_d   = run_mode_e'({1'b0, mode_q});
          step_depth_d = depth_q;
          frozen_d     = 1'b0;
        end
      end
      KIND_QUERY: begin
        if (!b_res_q.found) begin
          status = STATUS_NO_BP;
        end else begin
          num  = bp_id_q;
          hits = b_res_q.hits;
        end
      end
      default: begin
        stop = 1'b0;
      end
    endcase
    if (stop) frozen_d = 1'b1;
    if (!stop) reason = REASON_BP;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bot_q        <= 1'b0;
      run_mode_q   <= MODE_INITIAL;
      step_depth_q <= '0;
      next_num_q   <= 16'd1;
      last_valid_q <= 1'b0;
      last_slot_q  <= '1;
      last_num_q   <= '0;
      frozen_q     <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) bot_q <= cfg_data_i;
      done_q <= commit;
      if (commit) begin
        run_mode_q   <= run_mode_d;
        step_depth_q <= step_depth_d;
        next_num_q   <= next_num_d;
        last_valid_q <= last_valid_d;
        last_slot_q  <= last_slot_d;
        last_num_q   <= last_num_d;
        frozen_q     <= frozen_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      stopped_q    <= stop;
      reason_q     <= reason;
      hit_number_q <= num;
      stop_func_q  <= stop ? func_q : 16'd0;
      stop_pc_q    <= stop ? pc_q : 16'd0;
      stop_line_q  <= stop ? line_q : 16'd0;
      stop_depth_q <= stop ? depth_q : 16'd0;
      status_q     <= status;
      hits_q       <= hits;
    end
  end

  assign done_o       = done_q;
  assign stopped_o    = stopped_q;
  assign reason_o     = reason_q;
  assign hit_number_o = hit_number_q;
  assign stop_func_o  = stop_func_q;
  assign stop_pc_o    = stop_pc_q;
  assign stop_line_o  = stop_line_q;
  assign stop_depth_o = stop_depth_q;
  assign status_o     = status_q;
  assign hits_o       = hits_q;

endmodule

// ===== src/bsu_checker.sv =====
// Port-level checker of the breakpoint and step unit, bound to the top level.
`timescale 1ns / 1ps
`include "breakpoint_and_step_unit_macros.svh"

module bsu_checker import bsu_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic        stopped_o,
  input logic [1:0]  reason_o,
  input logic [15:0] stop_pc_o,
  input logic [1:0]  status_o
);

  `BSU_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)
  `BSU_ASSERT_IMP(a_done_idle, clk_i, rst_ni, done_o, !busy)
  `BSU_ASSERT_NXT(a_done_single, clk_i, rst_ni, done_o, !done_o)
  `BSU_ASSERT_IMP(a_run_clean, clk_i, rst_ni, done_o && !stopped_o,
                  reason_o == REASON_BP && stop_pc_o == 16'd0)
  `BSU_ASSERT_IMP(a_err_no_stop, clk_i, rst_ni, done_o && status_o != STATUS_OK, !stopped_o)

endmodule

bind breakpoint_and_step_unit bsu_checker u_bsu_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .start     (start),
  .busy      (busy),
  .done_o    (done_o),
  .stopped_o (stopped_o),
  .reason_o  (reason_o),
  .stop_pc_o (stop_pc_o),
  .status_o  (status_o)
);
